// ===== src/hcrh_pkg.sv =====
// shared types, constants and helpers for the heightfield cell ray hit block
`timescale 1ns / 1ps
`default_nettype none
package hcrh_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DIST_W = 31;
   localparam int QUOT_BITS = 31;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [15:0] EPSILON_RESET = 16'd1;

   // ray of one item
   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
   } ray_type;

   // one triangle after the dot products, ready for division
   typedef struct packed {
      logic               ok;
      logic               sat;
      logic [63:0]        aup;
      logic [63:0]        adown;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
   } lane_type;

   // one divider step
   typedef struct packed {
      logic                 ok;
      logic                 sat;
      logic [63:0]          r;
      logic [63:0]          den;
      logic [QUOT_BITS-1:0] q;
      logic signed [31:0]   ox;
      logic signed [31:0]   oy;
      logic signed [31:0]   dx;
      logic signed [31:0]   dy;
   } div_type;

   // one triangle after division
   typedef struct packed {
      logic               ok;
      logic [DIST_W-1:0]  d;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
   } quot_type;

   // clamp a 33-bit difference to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] res;
      if (v[32] != v[31]) begin
         res = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== src/hcrh_req_if.sv =====
// request channel: one heightfield cell and one ray per beat
`timescale 1ns / 1ps
`default_nettype none
interface hcrh_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] height_00;
   logic signed [31:0] height_10;
   logic signed [31:0] height_01;
   logic signed [31:0] height_11;
   logic signed [31:0] ray_origin_x;
   logic signed [31:0] ray_origin_y;
   logic signed [31:0] ray_origin_z;
   logic signed [31:0] ray_dir_x;
   logic signed [31:0] ray_dir_y;
   logic signed [31:0] ray_dir_z;
   logic [30:0]        best_distance;

   modport source (output valid, height_00, height_10, height_01, height_11,
                   ray_origin_x, ray_origin_y, ray_origin_z,
                   ray_dir_x, ray_dir_y, ray_dir_z, best_distance,
                   input ready);
   modport sink (input valid, height_00, height_10, height_01, height_11,
                 ray_origin_x, ray_origin_y, ray_origin_z,
                 ray_dir_x, ray_dir_y, ray_dir_z, best_distance,
                 output ready);
endinterface
`default_nettype wire

// ===== src/hcrh_rsp_if.sv =====
// response channel: hit result per beat
`timescale 1ns / 1ps
`default_nettype none
interface hcrh_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [30:0] new_distance;
   logic        which_triangle;

   modport source (output valid, hit, new_distance, which_triangle, input ready);
   modport sink (input valid, hit, new_distance, which_triangle, output ready);
endinterface
`default_nettype wire

// ===== src/heightfield_cell_ray_hit.sv =====
// top level: ray hit test against the two triangles of one heightfield cell
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    four corner heights, ray origin and direction, best distance
//  rsp      out  valid/ready    hit, new_distance, which_triangle
//  csr      in   write enable   epsilon
//
// one beat accepted per cycle while the output is not stalled; the pipeline has 4 front stages, 31 divider
// stages (one quotient bit each), 2 back stages and the output register.
// the two triangles run in parallel lanes with their own multipliers and divider.
// a stalled output freezes the whole pipeline; req.ready follows the output slot.
// reset clears the valid bits and sets epsilon to 1.
`timescale 1ns / 1ps
`default_nettype none
module heightfield_cell_ray_hit import hcrh_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hcrh_req_if.sink         req,
   hcrh_rsp_if.source       rsp,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   logic [15:0] epsilon_ff;
   logic        adv;
   ray_type     ray;

   logic fa_v, fb_v, da_v, db_v, ba_v, bb_v;
   lane_type lane_a, lane_b;
   quot_type quot_a, quot_b;
   logic [DIST_W-1:0] fa_b, fb_b, da_b, db_b, ba_b, bb_b;
   logic ok_a, ok_b;
   logic [DIST_W-1:0] dist_a, dist_b;

   logic rsp_valid_ff, hit_ff, tri_ff;
   logic [DIST_W-1:0] dist_ff;
   logic hit_in, tri_in;
   logic [DIST_W-1:0] dist_in, win;

   // epsilon register
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPSILON_RESET;
      end else if (csr_write_enable) begin
         epsilon_ff <= csr_write_data;
      end
   end

   // pipeline moves whenever the output slot is free or being taken
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   always_comb begin
      ray.ox = req.ray_origin_x;
      ray.oy = req.ray_origin_y;
      ray.oz = req.ray_origin_z;
      ray.dx = req.ray_dir_x;
      ray.dy = req.ray_dir_y;
      ray.dz = req.ray_dir_z;
   end

   // lower-left lane
   hcrh_front #(.FRAC_BITS(FRAC_BITS), .UPPER(1'b0)) u_front_a (
      .clock, .reset, .adv, .in_valid(req.valid),
      .nx_a(req.height_00), .nx_b(req.height_10),
      .ny_a(req.height_00), .ny_b(req.height_01),
      .corner_z(req.height_00), .ray, .best_in(req.best_distance),
      .epsilon(epsilon_ff), .out_valid(fa_v), .lane_out(lane_a), .best_out(fa_b)
   );

   hcrh_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
      .clock, .reset, .adv, .in_valid(fa_v), .lane_in(lane_a), .best_in(fa_b),
      .out_valid(da_v), .quot_out(quot_a), .best_out(da_b)
   );

   hcrh_back #(.FRAC_BITS(FRAC_BITS), .UPPER(1'b0)) u_back_a (
      .clock, .reset, .adv, .in_valid(da_v), .quot_in(quot_a), .best_in(da_b),
      .epsilon(epsilon_ff), .out_valid(ba_v), .tri_ok(ok_a), .tri_dist(dist_a),
      .best_out(ba_b)
   );

   // upper-right lane
   hcrh_front #(.FRAC_BITS(FRAC_BITS), .UPPER(1'b1)) u_front_b (
      .clock, .reset, .adv, .in_valid(req.valid),
      .nx_a(req.height_01), .nx_b(req.height_11),
      .ny_a(req.height_10), .ny_b(req.height_11),
      .corner_z(req.height_11), .ray, .best_in(req.best_distance),
      .epsilon(epsilon_ff), .out_valid(fb_v), .lane_out(lane_b), .best_out(fb_b)
   );

   hcrh_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
      .clock, .reset, .adv, .in_valid(fb_v), .lane_in(lane_b), .best_in(fb_b),
      .out_valid(db_v), .quot_out(quot_b), .best_out(db_b)
   );

   hcrh_back #(.FRAC_BITS(FRAC_BITS), .UPPER(1'b1)) u_back_b (
      .clock, .reset, .adv, .in_valid(db_v), .quot_in(quot_b), .best_in(db_b),
      .epsilon(epsilon_ff), .out_valid(bb_v), .tri_ok(ok_b), .tri_dist(dist_b),
      .best_out(bb_b)
   );

   // nearer triangle wins, lower-left on a tie; must beat the best so far
   always_comb begin
      win    = dist_a;
      tri_in = 1'b0;
      if (ok_b && (!ok_a || (dist_b < dist_a))) begin
         win    = dist_b;
         tri_in = 1'b1;
      end
      hit_in  = (ok_a || ok_b) && (win < ba_b);
      dist_in = hit_in ? win : ba_b;
      if (!hit_in) begin
         tri_in = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ba_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
         tri_ff  <= tri_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.hit            = hit_ff;
   assign rsp.new_distance   = dist_ff;
   assign rsp.which_triangle = tri_ff;

   // both lanes stay in lock step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (ba_v == bb_v) && (!ba_v || (ba_b == bb_b)))
      else $error("triangle lanes out of step");

   // a miss reports the lower-left code
   a_miss_tri: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.hit |-> !rsp.which_triangle)
      else $error("which_triangle set without a hit");

   // a hit distance is always above the threshold
   a_hit_dist: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hit |-> ({1'b0, rsp.new_distance} > {16'd0, epsilon_ff}))
      else $error("hit distance not above epsilon");

   // a winning triangle never comes from a rejected lane
   a_win_ok: assert property (@(posedge clock) disable iff (reset)
      ba_v && hit_in |-> (tri_in ? ok_b : ok_a))
      else $error("rejected triangle selected");

endmodule
`default_nettype wire

// ===== src/hcrh_front.sv =====
// per-triangle front end: normal, plane dot products and reject checks
`timescale 1ns / 1ps
`default_nettype none
module hcrh_front import hcrh_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter bit UPPER = 1'b0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] nx_a,
   input  wire logic signed [31:0] nx_b,
   input  wire logic signed [31:0] ny_a,
   input  wire logic signed [31:0] ny_b,
   input  wire logic signed [31:0] corner_z,
   input  wire ray_type            ray,
   input  wire logic [DIST_W-1:0]  best_in,
   input  wire logic [15:0]        epsilon,
   output logic                    out_valid,
   output lane_type                lane_out,
   output logic [DIST_W-1:0]       best_out
);

   localparam logic signed [32:0] ONE33 = 33'(64'd1 << FRAC_BITS);
   localparam logic signed [32:0] CXY = UPPER ? ONE33 : 33'sd0;
   localparam int SAT_SH = QUOT_BITS - FRAC_BITS;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [31:0] nx1_ff, ny1_ff, hx1_ff, hy1_ff, hz1_ff;
   ray_type r1_ff, r2_ff, r3_ff;
   logic [DIST_W-1:0] b1_ff, b2_ff, b3_ff, b4_ff;
   logic signed [63:0] pdx2_ff, pdy2_ff, phx2_ff, phy2_ff;
   logic signed [31:0] hz2_ff;
   logic signed [63:0] down3_ff, up3_ff;
   lane_type lane4_ff, lane4_in;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1: saturated normal and corner minus origin
   always_ff @(posedge clock) begin
      if (adv) begin
         nx1_ff <= sat32(33'(nx_a) - 33'(nx_b));
         ny1_ff <= sat32(33'(ny_a) - 33'(ny_b));
         hx1_ff <= sat32(CXY - 33'(ray.ox));
         hy1_ff <= sat32(CXY - 33'(ray.oy));
         hz1_ff <= sat32(33'(corner_z) - 33'(ray.oz));
         r1_ff  <= ray;
         b1_ff  <= best_in;
      end
   end

   // stage 2: products
   always_ff @(posedge clock) begin
      if (adv) begin
         pdx2_ff <= 64'(r1_ff.dx) * 64'(nx1_ff);
         pdy2_ff <= 64'(r1_ff.dy) * 64'(ny1_ff);
         phx2_ff <= 64'(hx1_ff) * 64'(nx1_ff);
         phy2_ff <= 64'(hy1_ff) * 64'(ny1_ff);
         hz2_ff  <= hz1_ff;
         r2_ff   <= r1_ff;
         b2_ff   <= b1_ff;
      end
   end

   // stage 3: floored products summed, z term has a unit normal component
   always_ff @(posedge clock) begin
      if (adv) begin
         down3_ff <= (pdx2_ff >>> FRAC_BITS) + (pdy2_ff >>> FRAC_BITS) + 64'(r2_ff.dz);
         up3_ff   <= (phx2_ff >>> FRAC_BITS) + (phy2_ff >>> FRAC_BITS) + 64'(hz2_ff);
         r3_ff    <= r2_ff;
         b3_ff    <= b2_ff;
      end
   end

   // stage 4: magnitudes, parallel and sign checks, quotient overflow
   always_comb begin
      lane4_in.adown = down3_ff[63] ? 64'(-down3_ff) : 64'(down3_ff);
      lane4_in.aup   = up3_ff[63] ? 64'(-up3_ff) : 64'(up3_ff);
      lane4_in.ok    = (lane4_in.adown > {48'd0, epsilon}) && (up3_ff != 64'sd0)
                       && (up3_ff[63] == down3_ff[63]);
      lane4_in.sat   = (lane4_in.aup >> SAT_SH) >= lane4_in.adown;
      lane4_in.ox    = r3_ff.ox;
      lane4_in.oy    = r3_ff.oy;
      lane4_in.dx    = r3_ff.dx;
      lane4_in.dy    = r3_ff.dy;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane4_ff <= lane4_in;
         b4_ff    <= b3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign lane_out  = lane4_ff;
   assign best_out  = b4_ff;

endmodule
`default_nettype wire

// ===== src/hcrh_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module hcrh_div import hcrh_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire lane_type          lane_in,
   input  wire logic [DIST_W-1:0] best_in,
   output logic                   out_valid,
   output quot_type               quot_out,
   output logic [DIST_W-1:0]      best_out
);

   div_type           stg_ff [QUOT_BITS];
   logic              vld_ff [QUOT_BITS];
   logic [DIST_W-1:0] bst_ff [QUOT_BITS];
   div_type           init;

   // numerator scaled by the fraction bits
   always_comb begin
      init.ok  = lane_in.ok;
      init.sat = lane_in.sat;
      init.r   = lane_in.aup << FRAC_BITS;
      init.den = lane_in.adown;
      init.q   = '0;
      init.ox  = lane_in.ox;
      init.oy  = lane_in.oy;
      init.dx  = lane_in.dx;
      init.dy  = lane_in.dy;
   end

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
      localparam int SH = QUOT_BITS - 1 - k;
      div_type src, nxt;
      logic    src_v;
      logic [DIST_W-1:0] src_b;

      if (k == 0) begin : g_first
         assign src   = init;
         assign src_v = in_valid;
         assign src_b = best_in;
      end else begin : g_next
         assign src   = stg_ff[k-1];
         assign src_v = vld_ff[k-1];
         assign src_b = bst_ff[k-1];
      end

      // trial subtract of the shifted divisor
      always_comb begin
         nxt = src;
         if ((src.r >> SH) >= src.den) begin
            nxt.r     = src.r - (src.den << SH);
            nxt.q[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[k] <= nxt;
            bst_ff[k] <= src_b;
         end
      end
   end

   // saturated quotient where the integer part overflows
   always_comb begin
      quot_out.ok = stg_ff[QUOT_BITS-1].ok;
      quot_out.d  = stg_ff[QUOT_BITS-1].sat ? DIST_MAX : stg_ff[QUOT_BITS-1].q;
      quot_out.ox = stg_ff[QUOT_BITS-1].ox;
      quot_out.oy = stg_ff[QUOT_BITS-1].oy;
      quot_out.dx = stg_ff[QUOT_BITS-1].dx;
      quot_out.dy = stg_ff[QUOT_BITS-1].dy;
   end

   assign out_valid = vld_ff[QUOT_BITS-1];
   assign best_out  = bst_ff[QUOT_BITS-1];

endmodule
`default_nettype wire

// ===== src/hcrh_back.sv =====
// per-triangle back end: distance threshold, hit point and inside test
`timescale 1ns / 1ps
`default_nettype none
module hcrh_back import hcrh_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter bit UPPER = 1'b0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire quot_type          quot_in,
   input  wire logic [DIST_W-1:0] best_in,
   input  wire logic [15:0]       epsilon,
   output logic                   out_valid,
   output logic                   tri_ok,
   output logic [DIST_W-1:0]      tri_dist,
   output logic [DIST_W-1:0]      best_out
);

   localparam logic signed [66:0] ONE67 = 67'(64'd1 << FRAC_BITS);

   logic v1_ff, v2_ff;
   logic ok1_ff, ok2_ff, ok2_in;
   logic [DIST_W-1:0] d1_ff, d2_ff, b1_ff, b2_ff;
   logic signed [63:0] mx1_ff, my1_ff;
   logic signed [31:0] ox1_ff, oy1_ff;
   logic signed [65:0] x, y;
   logic signed [66:0] xy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // stage 1: distance above threshold, scaled direction
   always_ff @(posedge clock) begin
      if (adv) begin
         ok1_ff <= quot_in.ok && ({1'b0, quot_in.d} > {16'd0, epsilon});
         mx1_ff <= 64'($signed({1'b0, quot_in.d})) * 64'(quot_in.dx);
         my1_ff <= 64'($signed({1'b0, quot_in.d})) * 64'(quot_in.dy);
         ox1_ff <= quot_in.ox;
         oy1_ff <= quot_in.oy;
         d1_ff  <= quot_in.d;
         b1_ff  <= best_in;
      end
   end

   // stage 2: hit point in the cell and triangle side test
   always_comb begin
      x  = 66'(ox1_ff) + 66'(mx1_ff >>> FRAC_BITS);
      y  = 66'(oy1_ff) + 66'(my1_ff >>> FRAC_BITS);
      xy = 67'(x) + 67'(y);
      if (UPPER) begin
         ok2_in = ok1_ff && (67'(x) <= ONE67) && (67'(y) <= ONE67) && (xy >= ONE67);
      end else begin
         ok2_in = ok1_ff && !x[65] && !y[65] && (xy <= ONE67);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ok2_ff <= ok2_in;
         d2_ff  <= d1_ff;
         b2_ff  <= b1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign tri_ok    = ok2_ff;
   assign tri_dist  = d2_ff;
   assign best_out  = b2_ff;

endmodule
`default_nettype wire
